### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CUA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define CUA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### sv/cua_pkg.sv
package cua_pkg;

  localparam int DATA_W     = 32;
  localparam int DIV_STAGES = DATA_W;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SUB     = 3'd1;
  localparam logic [2:0] OP_DIV     = 3'd2;
  localparam logic [2:0] OP_MUL     = 3'd3;
  localparam logic [2:0] OP_INC     = 3'd4;
  localparam logic [2:0] OP_DEC     = 3'd5;
  localparam logic [2:0] OP_MOD     = 3'd6;
  localparam logic [2:0] OP_INVALID = 3'd7;

  // Where the final value comes from at the end of the pipe
  localparam logic [1:0] SEL_ARITH = 2'd0;
  localparam logic [1:0] SEL_QUO   = 2'd1;
  localparam logic [1:0] SEL_REM   = 2'd2;

  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [2*DATA_W-1:0] dword_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] sel;
    word_t      value;
  } side_t;

  typedef struct packed {
    logic   is_mul;
    side_t  side;
    word_t  dividend;
    word_t  divisor;
    dword_t prod;
  } arith_t;

endpackage

### sv/cua_arith.sv
`include "assert_macros.svh"

module cua_arith
  import cua_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  logic [2:0] op,
  input  word_t      opa,
  input  word_t      opb,
  output logic       out_vld,
  output arith_t     res
);

  word_t         y;
  logic [DATA_W:0] sum;
  logic [DATA_W:0] diff;
  arith_t        res_nxt;
  arith_t        res_r;
  logic          vld_r;

  always_comb begin
    // inc and dec reuse the adder and subtractor with a unit operand
    y    = (op == OP_INC || op == OP_DEC) ? word_t'(1) : opb;
    sum  = {1'b0, opa} + {1'b0, y};
    diff = {1'b0, opa} - {1'b0, y};

    res_nxt.is_mul     = 1'b0;
    res_nxt.side.ok    = 1'b0;
    res_nxt.side.sel   = SEL_ARITH;
    res_nxt.side.value = '0;
    res_nxt.dividend   = opa;
    res_nxt.divisor    = opb;
    res_nxt.prod       = dword_t'(opa) * dword_t'(opb);

    unique case (op)
      OP_ADD, OP_INC: begin
        res_nxt.side.ok    = ~sum[DATA_W];
        res_nxt.side.value = res_nxt.side.ok ? sum[DATA_W-1:0] : '0;
      end
      OP_SUB, OP_DEC: begin
        res_nxt.side.ok    = ~diff[DATA_W];
        res_nxt.side.value = res_nxt.side.ok ? diff[DATA_W-1:0] : '0;
      end
      OP_DIV: begin
        res_nxt.side.ok  = |opb;
        res_nxt.side.sel = SEL_QUO;
      end
      OP_MOD: begin
        res_nxt.side.ok  = |opb;
        res_nxt.side.sel = SEL_REM;
      end
      OP_MUL: begin
        res_nxt.is_mul = 1'b1;
      end
      OP_INVALID: begin
        res_nxt.side.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld = vld_r;
  assign res     = res_r;

endmodule

### sv/cua_div_pipe.sv
`include "assert_macros.svh"

module cua_div_pipe
  import cua_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  word_t dividend,
  input  word_t divisor,
  input  side_t in_side,
  output logic  out_vld,
  output word_t quotient,
  output word_t remainder,
  output side_t out_side
);

  logic  vld_r  [DIV_STAGES];
  word_t r_r    [DIV_STAGES];
  word_t aq_r   [DIV_STAGES];
  word_t d_r    [DIV_STAGES];
  side_t side_r [DIV_STAGES];

  // One restoring step per stage: the dividend bits shift out of aq at the
  // top while quotient bits shift in at the bottom.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    word_t           r_prev;
    word_t           aq_prev;
    word_t           d_prev;
    side_t           s_prev;
    logic            v_prev;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            q;
    word_t           r_nxt;
    word_t           aq_nxt;

    if (i == 0) begin : g_first
      assign r_prev  = '0;
      assign aq_prev = dividend;
      assign d_prev  = divisor;
      assign s_prev  = in_side;
      assign v_prev  = in_vld;
    end else begin : g_next
      assign r_prev  = r_r[i-1];
      assign aq_prev = aq_r[i-1];
      assign d_prev  = d_r[i-1];
      assign s_prev  = side_r[i-1];
      assign v_prev  = vld_r[i-1];
    end

    always_comb begin
      trial  = {r_prev, aq_prev[DATA_W-1]};
      diff   = trial - {1'b0, d_prev};
      q      = ~diff[DATA_W];
      r_nxt  = q ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      aq_nxt = {aq_prev[DATA_W-2:0], q};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]    <= r_nxt;
        aq_r[i]   <= aq_nxt;
        d_r[i]    <= d_prev;
        side_r[i] <= s_prev;
      end
    end
  end

  assign out_vld   = vld_r[DIV_STAGES-1];
  assign quotient  = aq_r[DIV_STAGES-1];
  assign remainder = r_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

  `CUA_ASSERT(a_div_ok_nonzero,
    out_vld && out_side.ok && out_side.sel != SEL_ARITH |-> d_r[DIV_STAGES-1] != '0,
    "divide word marked good with a zero divisor")
  `CUA_ASSERT(a_hold_on_stall,
    !en |=> $stable(out_vld) && $stable(out_side),
    "last divider stage moved while stalled")
  `CUA_ASSERT_ALWAYS(a_reset_clears,
    !rst_n |=> !out_vld,
    "divider output valid after reset")

endmodule

### sv/checked_unsigned_alu_top.sv
// Checked unsigned ALU: add, sub, div, mul, inc, dec, mod with a fail flag.
// Pipeline from input accept to output valid: the input register, one
// add/sub/multiply stage, one divider stage per quotient bit and the output register.
// Throughput: one word per cycle; a stall on the output freezes the whole pipe.
// Reset (rst_n low, synchronous) clears every valid bit; data is not cleared.
`include "assert_macros.svh"

module checked_unsigned_alu_top
  import cua_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_ok,
  output logic [DATA_W-1:0] out_value
);

  logic       adv;
  logic       a_vld_r;
  logic [2:0] a_op_r;
  word_t      a_opa_r;
  word_t      a_opb_r;

  logic       b_vld;
  arith_t     b_res;
  side_t      b_side;
  logic       mul_ok;

  logic       d_vld;
  word_t      d_quo;
  word_t      d_rem;
  side_t      d_side;

  logic       out_valid_r;
  logic       out_ok_r;
  word_t      out_value_r;
  word_t      value_nxt;

  // Advance everything unless the output word is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r  <= in_action;
      a_opa_r <= in_operand_a;
      a_opb_r <= in_operand_b;
    end
  end

  cua_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (a_vld_r),
    .op      (a_op_r),
    .opa     (a_opa_r),
    .opb     (a_opb_r),
    .out_vld (b_vld),
    .res     (b_res)
  );

  // Product overflows when anything lands in the upper half
  always_comb begin
    mul_ok = ~|b_res.prod[2*DATA_W-1:DATA_W];
    b_side = b_res.side;
    if (b_res.is_mul) begin
      b_side.ok    = mul_ok;
      b_side.value = mul_ok ? b_res.prod[DATA_W-1:0] : '0;
    end
  end

  cua_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (b_vld),
    .dividend  (b_res.dividend),
    .divisor   (b_res.divisor),
    .in_side   (b_side),
    .out_vld   (d_vld),
    .quotient  (d_quo),
    .remainder (d_rem),
    .out_side  (d_side)
  );

  always_comb begin
    unique case (d_side.sel)
      SEL_QUO:   value_nxt = d_side.ok ? d_quo : '0;
      SEL_REM:   value_nxt = d_side.ok ? d_rem : '0;
      SEL_ARITH: value_nxt = d_side.value;
      default:   value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ok_r    <= d_side.ok;
      out_value_r <= value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_value = out_value_r;

  `CUA_ASSERT(a_fail_is_zero,
    out_valid_r && !out_ok_r |-> out_value_r == '0,
    "failed word carries a non-zero value")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cua_pkg::*;

  localparam word_t MAXW          = '1;
  localparam int    LONG_HOLD     = 256;
  localparam int    TAIL_CYCLES   = 40;
  localparam int    WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic  ok;
    word_t value;
  } answer_t;

  typedef struct {
    logic [2:0] op;
    word_t      a;
    word_t      b;
    bit         given;
    logic       ok;
    word_t      value;
  } vector_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_action;
  word_t      in_operand_a;
  word_t      in_operand_b;
  logic       out_valid;
  logic       out_stall;
  logic       out_ok;
  word_t      out_value;

  answer_t expected_answers[$];
  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      no_idle     = 1'b0;
  bit      hold_req    = 1'b0;

  // Typed expectations only where they read off directly; the rest go to the predictor.
  vector_t directed_vectors [0:23] = '{
    '{OP_ADD,     MAXW,          32'h0000_0000, 1'b1, 1'b1, MAXW},
    '{OP_ADD,     MAXW,          32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{OP_ADD,     32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
    '{OP_ADD,     32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{OP_SUB,     32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{OP_SUB,     MAXW,          MAXW,          1'b1, 1'b1, 32'h0},
    '{OP_SUB,     MAXW,          32'h0000_0000, 1'b1, 1'b1, MAXW},
    '{OP_DIV,     32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{OP_DIV,     MAXW,          32'h0000_0001, 1'b1, 1'b1, MAXW},
    '{OP_DIV,     32'h1234_5678, 32'h0000_0013, 1'b0, 1'b0, 32'h0},
    '{OP_MUL,     32'h0000_0000, MAXW,          1'b1, 1'b1, 32'h0},
    '{OP_MUL,     MAXW,          32'h0000_0000, 1'b1, 1'b1, 32'h0},
    '{OP_MUL,     32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0},
    '{OP_MUL,     32'h0000_FFFF, 32'h0001_0001, 1'b1, 1'b1, MAXW},
    '{OP_MUL,     MAXW,          MAXW,          1'b1, 1'b0, 32'h0},
    '{OP_INC,     MAXW,          32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{OP_INC,     32'h0000_0000, MAXW,          1'b1, 1'b1, 32'h1},
    '{OP_DEC,     32'h0000_0000, MAXW,          1'b1, 1'b0, 32'h0},
    '{OP_DEC,     MAXW,          32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFE},
    '{OP_MOD,     32'hDEAD_BEEF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{OP_MOD,     MAXW,          32'h0000_0010, 1'b1, 1'b1, 32'h0000_000F},
    '{OP_MOD,     32'h1234_5679, 32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{OP_INVALID, MAXW,          MAXW,          1'b1, 1'b0, 32'h0},
    '{OP_INVALID, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0}
  };

  checked_unsigned_alu_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_value    (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic answer_t alu_predict(input logic [2:0] op, input word_t a, input word_t b);
    answer_t         ans;
    logic [DATA_W:0] sum;
    dword_t          prod;
    ans  = '0;
    sum  = {1'b0, a} + {1'b0, b};
    prod = dword_t'(a) * dword_t'(b);
    case (op)
      OP_ADD: if (!sum[DATA_W]) ans = '{1'b1, sum[DATA_W-1:0]};
      OP_SUB: if (a >= b) ans = '{1'b1, a - b};
      OP_DIV: if (b != '0) ans = '{1'b1, a / b};
      OP_MUL: if (prod[2*DATA_W-1:DATA_W] == '0) ans = '{1'b1, prod[DATA_W-1:0]};
      OP_INC: if (a != MAXW) ans = '{1'b1, a + 1'b1};
      OP_DEC: if (a != '0) ans = '{1'b1, a - 1'b1};
      OP_MOD: if (b != '0) ans = '{1'b1, a % b};
      default: ans = '0;
    endcase
    return ans;
  endfunction

  // Mostly short gaps, a few long ones; none while no_idle holds.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MAXW;
      2: return word_t'(1);
      3: return word_t'($urandom_range(0, 255));
      4: return word_t'(1) << $urandom_range(0, DATA_W - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until taken, then queue its answer.
  task automatic send_word(input logic [2:0] op, input word_t a, input word_t b,
                           input answer_t ans);
    in_valid     <= 1'b1;
    in_action    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_answers.push_back(ans);
  endtask

  task automatic sender_gap();
    int n;
    n = idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and clock on until every queued answer is out; the next offer comes later.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_answers.size() != 0);
  endtask

  task automatic send_random(input int count);
    logic [2:0] op;
    word_t      a;
    word_t      b;
    for (int i = 0; i < count; i++) begin
      op = 3'($urandom_range(0, 7));
      a  = pick_operand();
      b  = pick_operand();
      // Steer a share of the words onto the overflow and borrow boundaries and onto small divisors.
      if ($urandom_range(0, 3) == 0) begin
        case (op)
          OP_ADD: b = MAXW - a + word_t'($urandom_range(0, 1));
          OP_SUB: b = a + word_t'($urandom_range(0, 1));
          OP_MUL: if (a != '0) b = MAXW / a + word_t'($urandom_range(0, 1));
          OP_DIV, OP_MOD: b = word_t'($urandom_range(0, 3));
          default: ;
        endcase
      end
      send_word(op, a, b, alu_predict(op, a, b));
      sender_gap();
    end
  endtask

  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t exp;
    if (rst_n) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_answers.size() == 0) begin
          $error("result with nothing expected: ok %0b value %h", out_ok, out_value);
          mismatches++;
        end else begin
          exp = expected_answers.pop_front();
          if (out_ok !== exp.ok) begin
            $error("field ok: expected %0b, actual %0b", exp.ok, out_ok);
            mismatches++;
          end
          if (out_value !== exp.value) begin
            $error("field value: expected %h, actual %h", exp.value, out_value);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= OP_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vectors[i]) begin
      send_word(directed_vectors[i].op, directed_vectors[i].a, directed_vectors[i].b,
                directed_vectors[i].given
                  ? answer_t'{directed_vectors[i].ok, directed_vectors[i].value}
                  : alu_predict(directed_vectors[i].op, directed_vectors[i].a,
                                directed_vectors[i].b));
      sender_gap();
    end
    wait_drained();

    // Back-to-back words, no idling either side.
    no_idle = 1'b1;
    send_random(100);

    // Hold the receiver off while words keep coming, so the pipe fills and stalls.
    hold_req = 1'b1;
    send_random(120);
    no_idle = 1'b0;
    wait_drained();

    send_random(480);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_answers.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/cua_pkg.sv
sv/cua_arith.sv
sv/cua_div_pipe.sv
sv/checked_unsigned_alu_top.sv
tb/tb.sv
